// File: design/bending_angle_forces_assert.svh
// assertion macros for the bending force pipeline
`ifndef BENDING_ANGLE_FORCES_ASSERT_SVH
`define BENDING_ANGLE_FORCES_ASSERT_SVH

`ifndef SYNTHESIS
`define BAF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define BAF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next cycle check failed");
`else
`define BAF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define BAF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: design/baf_pkg.sv
`default_nettype none
package baf_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int UDIV_STEPS = 30;
  localparam int FDIV_STEPS = 48;

  typedef logic signed [31:0] s32_t;
  typedef logic [31:0] mag_t;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam s32_t C_MAX = 32'sh4000_0000;
  localparam s32_t C_MIN = -32'sh4000_0000;
  localparam s32_t S32_MAX = 32'sh7fff_ffff;
  localparam s32_t S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [15:0] tag;
    logic [30:0] k;
  } ctx_t;

  typedef struct packed {
    logic [2:0] neg1;
    logic [2:0] neg2;
    mag_t [2:0] m1;
    mag_t [2:0] m2;
  } bond_t;

  typedef struct packed {
    logic [63:0] x;
    logic [34:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [31:0] len1;
    logic [31:0] len2;
    logic        degen;
  } len_t;

  typedef struct packed {
    logic [31:0] r;
    logic [30:0] q;
  } ud_t;

  typedef struct packed {
    logic [47:0] n;
    logic [31:0] r;
    logic [47:0] q;
  } fd_t;

  typedef struct packed {
    logic [15:0] tag;
    s32_t [2:0]  pf;
    s32_t [2:0]  pm;
    s32_t [2:0]  pl;
    logic        degen;
  } out_t;

endpackage
`default_nettype wire

// File: design/baf_in_if.sv
`default_nettype none
interface baf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle_tag;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic signed [31:0] middle_x;
  logic signed [31:0] middle_y;
  logic signed [31:0] middle_z;
  logic signed [31:0] last_x;
  logic signed [31:0] last_y;
  logic signed [31:0] last_z;
  logic [30:0] stiffness;

  modport source (
    output valid, angle_tag, first_x, first_y, first_z, middle_x, middle_y, middle_z,
           last_x, last_y, last_z, stiffness,
    input  ready
  );
  modport sink (
    input  valid, angle_tag, first_x, first_y, first_z, middle_x, middle_y, middle_z,
           last_x, last_y, last_z, stiffness,
    output ready
  );
endinterface
`default_nettype wire

// File: design/baf_out_if.sv
`default_nettype none
interface baf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tag_out;
  logic signed [31:0] push_first_x;
  logic signed [31:0] push_first_y;
  logic signed [31:0] push_first_z;
  logic signed [31:0] push_middle_x;
  logic signed [31:0] push_middle_y;
  logic signed [31:0] push_middle_z;
  logic signed [31:0] push_last_x;
  logic signed [31:0] push_last_y;
  logic signed [31:0] push_last_z;
  logic        degenerate;

  modport source (
    output valid, tag_out, push_first_x, push_first_y, push_first_z, push_middle_x,
           push_middle_y, push_middle_z, push_last_x, push_last_y, push_last_z,
           degenerate,
    input  ready
  );
  modport sink (
    input  valid, tag_out, push_first_x, push_first_y, push_first_z, push_middle_x,
           push_middle_y, push_middle_z, push_last_x, push_last_y, push_last_z,
           degenerate,
    output ready
  );
endinterface
`default_nettype wire

// File: design/bending_angle_forces.sv
`default_nettype none
`include "bending_angle_forces_assert.svh"
// Cosine bending force pipeline: takes one bead triple per clock and returns the three
// Q16.16 force increments in order, one word per clock. The latency is set by the
// 32-step bit-serial square root, the 30-step unit-vector divider and the 48-step
// force divider, each unrolled into one register stage per step. A word that waits at
// the output moves into a skid register; the pipeline holds only while that register
// is full, so input ready drops in the cycle after the first output stall.
module bending_angle_forces import baf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  baf_in_if.sink     in_chan,
  baf_out_if.source  out_chan
);

  localparam int ST_SQ0 = 2;
  localparam int ST_SQN = ST_SQ0 + SQRT_STEPS;
  localparam int ST_UD0 = ST_SQN + 1;
  localparam int ST_UDN = ST_UD0 + UDIV_STEPS;
  localparam int ST_CP  = ST_UDN + 1;
  localparam int ST_C   = ST_CP + 1;
  localparam int ST_CU  = ST_C + 1;
  localparam int ST_G   = ST_CU + 1;
  localparam int ST_FD0 = ST_G + 1;
  localparam int ST_FDN = ST_FD0 + FDIV_STEPS;
  localparam int LAST   = ST_FDN + 1;

  logic [LAST:0]    vld_r;
  logic             en;
  logic             skid_vld_r;
  out_t             skid_r;
  out_t             out_r;

  ctx_t             ctx_r   [0:ST_FDN];
  bond_t            bond_r  [0:ST_UDN];
  logic [2:0][63:0] sqm1_r;
  logic [2:0][63:0] sqm2_r;
  sq_t              sq1_r   [ST_SQ0:ST_SQN];
  sq_t              sq2_r   [ST_SQ0:ST_SQN];
  len_t             lens_r  [ST_UD0:ST_FDN];
  ud_t [2:0]        ud1_r   [ST_UD0:ST_UDN];
  ud_t [2:0]        ud2_r   [ST_UD0:ST_UDN];
  s32_t [2:0]       u1_r    [ST_CP:ST_CU];
  s32_t [2:0]       u2_r    [ST_CP:ST_CU];
  logic [2:0][62:0] cp_r;
  s32_t             c_r;
  logic [2:0][63:0] cu1_r;
  logic [2:0][63:0] cu2_r;
  logic [5:0][31:0] gm_r;
  logic [5:0]       gneg_r;
  fd_t [5:0]        fd_r    [ST_FD0:ST_FDN];
  logic [5:0]       fneg_r  [ST_FD0:ST_FDN];

  bond_t            bond_nxt;
  len_t             lens_nxt;
  ud_t [2:0]        ud1_nxt;
  ud_t [2:0]        ud2_nxt;
  s32_t [2:0]       u1_nxt;
  s32_t [2:0]       u2_nxt;
  logic [2:0][62:0] cp_nxt;
  s32_t             c_nxt;
  logic [5:0][31:0] gm_nxt;
  logic [5:0]       gneg_nxt;
  fd_t [5:0]        fd_nxt;
  logic [5:0]       fneg_nxt;
  out_t             out_nxt;
  out_t             out_sel;

  function automatic s32_t sat_sub(input s32_t a, input s32_t b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      return d[32] ? S32_MIN : S32_MAX;
    end
    return s32_t'(d[31:0]);
  endfunction

  function automatic sq_t sqrt_step(input sq_t s);
    sq_t         o;
    logic [34:0] rt;
    logic [34:0] trial;
    rt    = {s.rem[32:0], s.x[63:62]};
    trial = {1'b0, s.root, 2'b01};
    o.x   = {s.x[61:0], 2'b00};
    if (rt >= trial) begin
      o.rem  = rt - trial;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = rt;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic ud_t ud_step(input ud_t s, input logic [31:0] len);
    ud_t         o;
    logic [32:0] r2;
    logic        b;
    r2  = {s.r, 1'b0};
    b   = (r2 >= {1'b0, len});
    o.r = b ? 32'(r2 - {1'b0, len}) : r2[31:0];
    o.q = {s.q[29:0], b};
    return o;
  endfunction

  function automatic fd_t fd_step(input fd_t s, input logic [31:0] len);
    fd_t         o;
    logic [32:0] r2;
    logic        b;
    r2  = {s.r, s.n[47]};
    b   = (r2 >= {1'b0, len});
    o.r = b ? 32'(r2 - {1'b0, len}) : r2[31:0];
    o.n = {s.n[46:0], 1'b0};
    o.q = {s.q[46:0], b};
    return o;
  endfunction

  function automatic logic signed [33:0] shr30(input logic signed [63:0] v);
    logic [63:0] m;
    logic [33:0] t;
    m = v[63] ? 64'(-v) : 64'(v);
    t = m[63:30];
    return v[63] ? -$signed(t) : $signed(t);
  endfunction

  function automatic s32_t sat50(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return S32_MAX;
    end
    if (v < -50'sd2147483648) begin
      return S32_MIN;
    end
    return s32_t'(v[31:0]);
  endfunction

  assign en = !skid_vld_r;
  assign in_chan.ready = en;

  // bond vectors
  always_comb begin
    s32_t [2:0] pf;
    s32_t [2:0] pm;
    s32_t [2:0] pl;
    s32_t       d1;
    s32_t       d2;
    pf = {in_chan.first_z, in_chan.first_y, in_chan.first_x};
    pm = {in_chan.middle_z, in_chan.middle_y, in_chan.middle_x};
    pl = {in_chan.last_z, in_chan.last_y, in_chan.last_x};
    for (int j = 0; j < 3; j++) begin
      d1 = sat_sub(pm[j], pf[j]);
      d2 = sat_sub(pl[j], pm[j]);
      bond_nxt.neg1[j] = d1[31];
      bond_nxt.neg2[j] = d2[31];
      bond_nxt.m1[j]   = d1[31] ? 32'(-d1) : 32'(d1);
      bond_nxt.m2[j]   = d2[31] ? 32'(-d2) : 32'(d2);
    end
  end

  // lengths and first quotient bit of the unit vectors
  always_comb begin
    logic [31:0] m;
    lens_nxt.len1  = sq1_r[ST_SQN].root;
    lens_nxt.len2  = sq2_r[ST_SQN].root;
    lens_nxt.degen = (lens_nxt.len1 == '0) || (lens_nxt.len2 == '0);
    for (int j = 0; j < 3; j++) begin
      m = bond_r[ST_SQN].m1[j];
      ud1_nxt[j].q = {30'd0, m >= lens_nxt.len1};
      ud1_nxt[j].r = (m >= lens_nxt.len1) ? m - lens_nxt.len1 : m;
      m = bond_r[ST_SQN].m2[j];
      ud2_nxt[j].q = {30'd0, m >= lens_nxt.len2};
      ud2_nxt[j].r = (m >= lens_nxt.len2) ? m - lens_nxt.len2 : m;
    end
  end

  // signed unit components and their products
  always_comb begin
    logic [30:0] q1;
    logic [30:0] q2;
    logic [61:0] p;
    for (int j = 0; j < 3; j++) begin
      q1 = ud1_r[ST_UDN][j].q;
      q2 = ud2_r[ST_UDN][j].q;
      u1_nxt[j] = bond_r[ST_UDN].neg1[j] ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
      u2_nxt[j] = bond_r[ST_UDN].neg2[j] ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
      p = q1 * q2;
      cp_nxt[j] = (bond_r[ST_UDN].neg1[j] ^ bond_r[ST_UDN].neg2[j]) ?
                  63'(-{1'b0, p}) : {1'b0, p};
    end
  end

  // cosine, truncated and clamped
  always_comb begin
    logic signed [62:0] cs;
    logic [62:0]        cm;
    logic [32:0]        csh;
    cs  = $signed(cp_r[0]) + $signed(cp_r[1]) + $signed(cp_r[2]);
    cm  = cs[62] ? 63'(-cs) : 63'(cs);
    csh = cm[62:30];
    if (csh > {2'b00, ONE_Q30}) begin
      csh = {2'b00, ONE_Q30};
    end
    c_nxt = cs[62] ? -$signed(csh[31:0]) : $signed(csh[31:0]);
  end

  // direction terms
  always_comb begin
    logic signed [33:0] g1;
    logic signed [33:0] g3;
    for (int j = 0; j < 3; j++) begin
      g1 = shr30($signed(cu1_r[j])) - 34'($signed(u2_r[ST_CU][j]));
      g3 = 34'($signed(u1_r[ST_CU][j])) - shr30($signed(cu2_r[j]));
      gneg_nxt[j]     = g1[33];
      gneg_nxt[j + 3] = g3[33];
      gm_nxt[j]       = g1[33] ? 32'(-g1) : 32'(g1);
      gm_nxt[j + 3]   = g3[33] ? 32'(-g3) : 32'(g3);
    end
  end

  // scale by stiffness
  always_comb begin
    logic [62:0] p;
    for (int j = 0; j < 6; j++) begin
      p = ctx_r[ST_G].k * gm_r[j];
      fd_nxt[j].n = p[61:14];
      fd_nxt[j].r = '0;
      fd_nxt[j].q = '0;
    end
    fneg_nxt = gneg_r;
  end

  // final forces
  always_comb begin
    logic signed [49:0] f1;
    logic signed [49:0] f3;
    logic signed [49:0] f2;
    out_nxt.tag   = ctx_r[ST_FDN].tag;
    out_nxt.degen = lens_r[ST_FDN].degen;
    for (int j = 0; j < 3; j++) begin
      f1 = fneg_r[ST_FDN][j] ? -$signed({2'b00, fd_r[ST_FDN][j].q}) :
                               $signed({2'b00, fd_r[ST_FDN][j].q});
      f3 = fneg_r[ST_FDN][j + 3] ? -$signed({2'b00, fd_r[ST_FDN][j + 3].q}) :
                                   $signed({2'b00, fd_r[ST_FDN][j + 3].q});
      f2 = -(f1 + f3);
      if (lens_r[ST_FDN].degen) begin
        out_nxt.pf[j] = '0;
        out_nxt.pm[j] = '0;
        out_nxt.pl[j] = '0;
      end else begin
        out_nxt.pf[j] = sat50(f1);
        out_nxt.pm[j] = sat50(f2);
        out_nxt.pl[j] = sat50(f3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_chan.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= '{tag: in_chan.angle_tag, k: in_chan.stiffness};
      for (int i = 1; i <= ST_FDN; i++) begin
        ctx_r[i] <= ctx_r[i-1];
      end
      bond_r[0] <= bond_nxt;
      for (int i = 1; i <= ST_UDN; i++) begin
        bond_r[i] <= bond_r[i-1];
      end
      for (int j = 0; j < 3; j++) begin
        sqm1_r[j] <= bond_r[0].m1[j] * bond_r[0].m1[j];
        sqm2_r[j] <= bond_r[0].m2[j] * bond_r[0].m2[j];
      end
      sq1_r[ST_SQ0] <= {sqm1_r[0] + sqm1_r[1] + sqm1_r[2], 35'd0, 32'd0};
      sq2_r[ST_SQ0] <= {sqm2_r[0] + sqm2_r[1] + sqm2_r[2], 35'd0, 32'd0};
      for (int i = ST_SQ0 + 1; i <= ST_SQN; i++) begin
        sq1_r[i] <= sqrt_step(sq1_r[i-1]);
        sq2_r[i] <= sqrt_step(sq2_r[i-1]);
      end
      lens_r[ST_UD0] <= lens_nxt;
      for (int i = ST_UD0 + 1; i <= ST_FDN; i++) begin
        lens_r[i] <= lens_r[i-1];
      end
      ud1_r[ST_UD0] <= ud1_nxt;
      ud2_r[ST_UD0] <= ud2_nxt;
      for (int i = ST_UD0 + 1; i <= ST_UDN; i++) begin
        for (int j = 0; j < 3; j++) begin
          ud1_r[i][j] <= ud_step(ud1_r[i-1][j], lens_r[i-1].len1);
          ud2_r[i][j] <= ud_step(ud2_r[i-1][j], lens_r[i-1].len2);
        end
      end
      u1_r[ST_CP] <= u1_nxt;
      u2_r[ST_CP] <= u2_nxt;
      for (int i = ST_CP + 1; i <= ST_CU; i++) begin
        u1_r[i] <= u1_r[i-1];
        u2_r[i] <= u2_r[i-1];
      end
      cp_r <= cp_nxt;
      c_r  <= c_nxt;
      for (int j = 0; j < 3; j++) begin
        cu1_r[j] <= c_r * $signed(u1_r[ST_C][j]);
        cu2_r[j] <= c_r * $signed(u2_r[ST_C][j]);
      end
      gm_r   <= gm_nxt;
      gneg_r <= gneg_nxt;
      fd_r[ST_FD0]   <= fd_nxt;
      fneg_r[ST_FD0] <= fneg_nxt;
      for (int i = ST_FD0 + 1; i <= ST_FDN; i++) begin
        for (int j = 0; j < 3; j++) begin
          fd_r[i][j]     <= fd_step(fd_r[i-1][j], lens_r[i-1].len1);
          fd_r[i][j + 3] <= fd_step(fd_r[i-1][j + 3], lens_r[i-1].len2);
        end
        fneg_r[i] <= fneg_r[i-1];
      end
      out_r <= out_nxt;
    end
  end

  // skid register behind the last stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_chan.ready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (vld_r[LAST] && !out_chan.ready) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r) begin
      skid_r <= out_r;
    end
  end

  assign out_sel        = skid_vld_r ? skid_r : out_r;
  assign out_chan.valid = skid_vld_r || vld_r[LAST];
  assign out_chan.tag_out       = out_sel.tag;
  assign out_chan.push_first_x  = out_sel.pf[0];
  assign out_chan.push_first_y  = out_sel.pf[1];
  assign out_chan.push_first_z  = out_sel.pf[2];
  assign out_chan.push_middle_x = out_sel.pm[0];
  assign out_chan.push_middle_y = out_sel.pm[1];
  assign out_chan.push_middle_z = out_sel.pm[2];
  assign out_chan.push_last_x   = out_sel.pl[0];
  assign out_chan.push_last_y   = out_sel.pl[1];
  assign out_chan.push_last_z   = out_sel.pl[2];
  assign out_chan.degenerate    = out_sel.degen;

  `BAF_ASSERT_IMPLY(a_degen_zero, clk, rst_n, out_chan.valid && out_chan.degenerate, out_chan.push_first_x == 0 && out_chan.push_middle_x == 0 && out_chan.push_last_x == 0 && out_chan.push_first_y == 0 && out_chan.push_middle_y == 0 && out_chan.push_last_y == 0 && out_chan.push_first_z == 0 && out_chan.push_middle_z == 0 && out_chan.push_last_z == 0)
  `BAF_ASSERT_NEXT(a_stall_hold, clk, rst_n, !en, $stable(vld_r))
  `BAF_ASSERT_IMPLY(a_unit_range, clk, rst_n, vld_r[ST_UDN] && !lens_r[ST_UDN].degen, ud1_r[ST_UDN][0].q <= ONE_Q30 && ud2_r[ST_UDN][0].q <= ONE_Q30)
  `BAF_ASSERT_IMPLY(a_cos_range, clk, rst_n, vld_r[ST_C], c_r <= C_MAX && c_r >= C_MIN)

endmodule
`default_nettype wire
